### sv/fei_pkg.sv
`default_nettype none
package fei_pkg;
	localparam int FracBits = 16;
	localparam int DecelW = 24;
	localparam int DtW = 24;
	localparam logic [DecelW-1:0] DecelReset = 24'd19268;

	typedef enum logic [1:0] {
		MODE_STEP = 2'd0,
		MODE_IMPULSE = 2'd1,
		MODE_TRANS = 2'd2,
		MODE_SETPOS = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic [DtW-1:0] time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic stopped;
		logic saturated;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item, start
		logic sq_step;   // accumulate one square (index in idx)
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;  // start divide for component idx
		logic div_step;
		logic div_done;  // apply quotient to component idx
		logic pos_step;  // position update for component idx
		logic finish;    // apply mode effects, form result
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic zero_vel;
		logic stop_all;  // dv > speed
	} stat_t;
endpackage
`default_nettype wire

### sv/fei_if.sv
`default_nettype none
interface fei_in_if;
	logic valid;
	logic ready;
	fei_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fei_out_if;
	logic valid;
	logic ready;
	fei_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fei_cfg_if;
	logic valid;
	logic ready;
	logic [fei_pkg::DecelW-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/friction_euler_integrator.sv
`default_nettype none
// One body integrator. Each input transfer yields one output transfer. Impulse,
// set-position and translation go from the accept state straight to the result
// state. A step runs through the accept state, the squaring of each component, a
// bit-serial square root of the squared speed, a check state, then per component a
// restoring divide of |v|*dv by the speed (setup, 64 steps, writeback), the
// position update of each component and a result state. At rest or when friction
// stops the body the divides are skipped.
// The next item is taken once the result register has been emptied.
// The user must write friction_decel through cfg only while no item is in flight; the block does not check.
module friction_euler_integrator (
	input wire logic clk,
	input wire logic arst_n,
	fei_in_if.sink in_ch,
	fei_out_if.source out_ch,
	fei_cfg_if.sink cfg
);
	fei_pkg::cmd_t cmd;
	fei_pkg::stat_t stat;
	logic idle;
	logic out_valid_q;
	logic [fei_pkg::DecelW-1:0] decel_q;
	logic in_fire;

	assign in_ch.ready = idle;
	assign in_fire = in_ch.valid && idle;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decel_q <= fei_pkg::DecelReset;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid)
				decel_q <= cfg.data;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end
	assign out_ch.valid = out_valid_q;

	fei_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .mode(in_ch.data.mode),
		.stat(stat), .out_busy(out_valid_q), .cmd(cmd), .idle(idle)
	);

	fei_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(in_ch.data), .decel(decel_q),
		.stat(stat), .result(out_ch.data)
	);
endmodule
`default_nettype wire

### sv/fei_ctrl.sv
`default_nettype none
module fei_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic [1:0] mode,
	input wire fei_pkg::stat_t stat,
	input wire logic out_busy,
	output fei_pkg::cmd_t cmd,
	output logic idle
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQ   = 9'b000000010,
		S_SQRT = 9'b000000100,
		S_CHK  = 9'b000001000,
		S_DIVI = 9'b000010000,
		S_DIV  = 9'b000100000,
		S_DIVD = 9'b001000000,
		S_POS  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [1:0] idx_q;
	logic [5:0] cnt_q;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		idle = 1'b0;
		case (state_q)
			S_IDLE: begin
				idle = !out_busy;
				cmd.load = in_fire;
			end
			S_SQ: cmd.sq_step = 1'b1;
			S_SQRT: cmd.sqrt_step = 1'b1;
			S_CHK: cmd.sqrt_init = 1'b0;
			S_DIVI: cmd.div_init = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_DIVD: cmd.div_done = 1'b1;
			S_POS: cmd.pos_step = 1'b1;
			S_FIN: cmd.finish = 1'b1;
			default: ;
		endcase
		if (state_q == S_SQ && idx_q == 2'd2)
			cmd.sqrt_init = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_fire)
						state_q <= (fei_pkg::mode_t'(mode) == fei_pkg::MODE_STEP)
							? S_SQ : S_FIN;
				end
				S_SQ: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						cnt_q <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32)
						state_q <= S_CHK;
				end
				S_CHK: begin
					if (stat.zero_vel || stat.stop_all)
						state_q <= S_POS;
					else
						state_q <= S_DIVI;
				end
				S_DIVI: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= S_DIVD;
				end
				S_DIVD: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						state_q <= S_POS;
					end else
						state_q <= S_DIVI;
				end
				S_POS: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/fei_dp.sv
`default_nettype none
module fei_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire fei_pkg::cmd_t cmd,
	input wire fei_pkg::in_item_t item,
	input wire logic [fei_pkg::DecelW-1:0] decel,
	output fei_pkg::stat_t stat,
	output fei_pkg::out_item_t result
);
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] rep_q [3];
	fei_pkg::in_item_t item_q;
	logic [65:0] sumsq_q;
	logic [65:0] rem_q;
	logic [32:0] root_q;
	logic [47:0] dv_q;
	logic [63:0] dnum_q;   // shifting dividend / quotient
	logic [64:0] drem_q;
	logic clip_q;
	logic [5:0] sqrt_cnt_q;

	logic [31:0] mag_v;
	logic [63:0] sq_v;
	logic [67:0] trial;
	logic [65:0] bitv;
	logic [5:0] sstep;
	logic [64:0] dsh;
	logic [31:0] nm;
	logic [55:0] prod;
	logic [39:0] pmag;
	logic signed [41:0] psum;
	logic signed [33:0] tdiff [3];
	logic [63:0] mdv;

	always_comb begin
		mag_v = vel_q[cmd.idx][31] ? 32'(-vel_q[cmd.idx]) : 32'(vel_q[cmd.idx]);
		sq_v = 64'(mag_v) * 64'(mag_v);
		mdv = 64'(mag_v) * 64'(dv_q[31:0]);
		prod = 56'(mag_v) * 56'(item_q.time_step);
		pmag = 40'(prod >> fei_pkg::FracBits);
		psum = 42'(pos_q[cmd.idx])
			+ (vel_q[cmd.idx][31] ? -42'(pmag) : 42'(pmag));
		nm = mag_v - dnum_q[31:0];
		dsh = {drem_q[63:0], dnum_q[63]};
		for (int i = 0; i < 3; i++)
			tdiff[i] = 34'(pos_q[i]) - 34'(rep_q[i]);
	end

	// restoring integer square root, one result bit per step from the top
	always_comb begin
		sstep = 6'(sqrt_cnt_q);
		bitv = 66'd1 << {sstep, 1'b0};
		trial = 68'(rem_q) - 68'({root_q, 33'd0} >> (6'd32 - sstep)) - 68'(bitv);
	end

	assign stat.zero_vel = (sumsq_q == '0);
	assign stat.stop_all = (dv_q > 48'(root_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				rep_q[i] <= '0;
			end
			clip_q <= 1'b0;
			sqrt_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				item_q <= item;
				sumsq_q <= '0;
				clip_q <= 1'b0;
				dv_q <= 48'((64'(decel) * 64'(item.time_step)) >> fei_pkg::FracBits);
			end
			if (cmd.sq_step)
				sumsq_q <= sumsq_q + 66'(sq_v);
			if (cmd.sqrt_init) begin
				rem_q <= sumsq_q + 66'(sq_v);
				root_q <= '0;
				sqrt_cnt_q <= 6'd32;
			end
			if (cmd.sqrt_step) begin
				// root bit k set if (root<<(k+1) + 4^k) <= rem
				if (!trial[67]) begin
					rem_q <= trial[65:0];
					root_q <= root_q | (33'd1 << sstep);
				end
				sqrt_cnt_q <= sqrt_cnt_q - 6'd1;
			end
			if (cmd.div_init) begin
				dnum_q <= mdv;
				drem_q <= '0;
			end
			if (cmd.div_step) begin
				if (dsh >= 65'(root_q)) begin
					drem_q <= dsh - 65'(root_q);
					dnum_q <= {dnum_q[62:0], 1'b1};
				end else begin
					drem_q <= dsh;
					dnum_q <= {dnum_q[62:0], 1'b0};
				end
			end
			if (cmd.div_done)
				vel_q[cmd.idx] <= vel_q[cmd.idx][31] ? -$signed(nm) : $signed(nm);
			if (cmd.pos_step) begin
				if (!stat.zero_vel && stat.stop_all) begin
					// velocity cleared; position unchanged
					vel_q[cmd.idx] <= '0;
				end else if (psum > 42'sd2147483647) begin
					pos_q[cmd.idx] <= 32'sh7fffffff;
					clip_q <= 1'b1;
				end else if (psum < -42'sd2147483648) begin
					pos_q[cmd.idx] <= 32'sh80000000;
					clip_q <= 1'b1;
				end else
					pos_q[cmd.idx] <= 32'(psum);
			end
			if (cmd.finish) begin
				case (fei_pkg::mode_t'(item_q.mode))
					fei_pkg::MODE_IMPULSE: begin
						vel_q[0] <= item_q.in_x;
						vel_q[1] <= item_q.in_y;
						vel_q[2] <= item_q.in_z;
						result.out_x <= pos_q[0];
						result.out_y <= pos_q[1];
						result.out_z <= pos_q[2];
						result.vel_x <= item_q.in_x;
						result.vel_y <= item_q.in_y;
						result.vel_z <= item_q.in_z;
						result.stopped <= ({item_q.in_x, item_q.in_y, item_q.in_z} == '0);
						result.saturated <= 1'b0;
					end
					fei_pkg::MODE_SETPOS: begin
						pos_q[0] <= item_q.in_x;
						pos_q[1] <= item_q.in_y;
						pos_q[2] <= item_q.in_z;
						rep_q[0] <= item_q.in_x;
						rep_q[1] <= item_q.in_y;
						rep_q[2] <= item_q.in_z;
						result.out_x <= item_q.in_x;
						result.out_y <= item_q.in_y;
						result.out_z <= item_q.in_z;
						result.vel_x <= vel_q[0];
						result.vel_y <= vel_q[1];
						result.vel_z <= vel_q[2];
						result.stopped <= ({vel_q[0], vel_q[1], vel_q[2]} == '0);
						result.saturated <= 1'b0;
					end
					fei_pkg::MODE_TRANS: begin
						result.saturated <= 1'b0;
						if (tdiff[0] > 34'sd2147483647) begin
							result.out_x <= 32'sh7fffffff; result.saturated <= 1'b1;
						end else if (tdiff[0] < -34'sd2147483648) begin
							result.out_x <= 32'sh80000000; result.saturated <= 1'b1;
						end else
							result.out_x <= 32'(tdiff[0]);
						if (tdiff[1] > 34'sd2147483647) begin
							result.out_y <= 32'sh7fffffff; result.saturated <= 1'b1;
						end else if (tdiff[1] < -34'sd2147483648) begin
							result.out_y <= 32'sh80000000; result.saturated <= 1'b1;
						end else
							result.out_y <= 32'(tdiff[1]);
						if (tdiff[2] > 34'sd2147483647) begin
							result.out_z <= 32'sh7fffffff; result.saturated <= 1'b1;
						end else if (tdiff[2] < -34'sd2147483648) begin
							result.out_z <= 32'sh80000000; result.saturated <= 1'b1;
						end else
							result.out_z <= 32'(tdiff[2]);
						for (int i = 0; i < 3; i++)
							rep_q[i] <= pos_q[i];
						result.vel_x <= vel_q[0];
						result.vel_y <= vel_q[1];
						result.vel_z <= vel_q[2];
						result.stopped <= ({vel_q[0], vel_q[1], vel_q[2]} == '0);
					end
					default: begin
						result.out_x <= pos_q[0];
						result.out_y <= pos_q[1];
						result.out_z <= pos_q[2];
						result.vel_x <= vel_q[0];
						result.vel_y <= vel_q[1];
						result.vel_z <= vel_q[2];
						result.stopped <= ({vel_q[0], vel_q[1], vel_q[2]} == '0);
						result.saturated <= clip_q;
					end
				endcase
			end
		end
	end
endmodule
`default_nettype wire
